@@ src/tprd_pkg.sv @@
// Package for the touchpad report decoder: IDs, event and verdict codes.
// No dependencies.
package tprd_pkg;
  localparam int MAX_CONTACTS = 16;
  localparam int CID_W = 4;
  localparam logic [7:0] ID_AUDIO = 8'h3E;
  localparam logic [7:0] ID_TOUCH = 8'h33;
  localparam logic [7:0] ID_DOUBLE = 8'h34;
  localparam logic [7:0] ID_KEYBOARD = 8'h01;
  localparam logic [7:0] ID_MOUSE = 8'h02;
  localparam logic [1:0] EV_CONTACT = 2'd0;
  localparam logic [1:0] EV_FRAME = 2'd1;
  localparam logic [1:0] EV_BUTTON = 2'd2;
  localparam logic [1:0] EV_DONE = 2'd3;
  localparam logic [1:0] VD_PASS = 2'd0;
  localparam logic [1:0] VD_CONSUMED = 2'd1;
  localparam logic [1:0] VD_KEYBOARD = 2'd2;
  localparam logic [1:0] VD_SIZE_ERR = 2'd3;
  localparam logic [0:0] REG_AUDIO = 1'd0;
  localparam logic [0:0] REG_MT = 1'd1;
  typedef struct packed {
    logic       last;
    logic       audio_inserted;
    logic       audio_update;
    logic [1:0] verdict;
    logic       button_pressed;
    logic [1:0] button_id;
    logic       any_touch;
    logic [11:0] pos_y;
    logic [11:0] pos_x;
    logic       touch_active;
    logic [3:0] track_id;
    logic [1:0] event_kind;
  } result_t;
endpackage

@@ src/touchpad_report_decoder.sv @@
// Touchpad report decoder top level: byte parser, contact table memory,
// event sequencer. Depends on tprd_pkg.
// Bytes pass the idle and byte states; contact events leave from the byte state. A
// report end passes the frame (touch report with contacts), button (touch report)
// and done states. Disconnect reads out each active contact, a frame end if any,
// buttons and done. One item in work at a time; each result also waits for a free output.
// Reset (rst, synchronous) clears the active bits, buttons and parser state.
module touchpad_report_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // byte_value[7:0], report_size[15:8]
  input  logic        s_tuser,  // command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,  // event_kind, track_id, touch_active, pos_x, pos_y,
                                // any_touch, button_id, button_pressed, verdict,
                                // audio_update, audio_inserted (zero fill)
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic        cfg_wdata
);
  localparam int MAX_CONTACTS_IDX = tprd_pkg::MAX_CONTACTS - 1;
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_BYTE = 3'd1;
  localparam logic [2:0] S_FRAME = 3'd2;
  localparam logic [2:0] S_BTN = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;
  localparam logic [2:0] S_DISC = 3'd5;
  localparam logic [2:0] S_DREAD = 3'd6;

  logic [2:0] state;
  logic audio_en, mt_en;
  logic [15:0] active;
  logic [23:0] pos_mem [MAX_CONTACTS_IDX:0];
  logic [23:0] rd_data;
  logic [3:0] rd_addr;
  logic mem_we;
  logic [2:0] held, nbtn;
  logic [7:0] bidx, rid, in_byte, in_size;
  logic [23:0] rec;
  logic any_t, size_bad, aud_nz, disc;
  logic [1:0] btn;
  logic [4:0] scan;
  logic disc_sent;
  tprd_pkg::result_t res, res_next;
  logic res_valid, res_load, out_free;

  logic is_audio, touch_ok, at_end, rec_end, cid_ok;
  logic [7:0] sz;
  logic [3:0] cid;
  logic t;
  logic [11:0] px, py;
  logic [1:0] verdict;
  logic [2:0] chg;

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = res_valid;
  assign m_tlast = res.last;
  assign m_tdata = {1'b0, res[38:0]};

  always_ff @(posedge clk) begin
    if (mem_we) pos_mem[cid] <= {py, px};
    rd_data <= pos_mem[rd_addr];
  end

  always_comb begin
    sz = (in_size == 8'd0) ? 8'd1 : in_size;
    is_audio = audio_en && rid == tprd_pkg::ID_AUDIO;
    touch_ok = !is_audio && mt_en && rid == tprd_pkg::ID_TOUCH && !size_bad;
    at_end = ({1'b0, bidx} + 9'd1) >= {1'b0, sz};
    rec_end = touch_ok && (bidx >= 8'd2) && (bidx[1:0] == 2'd1);
    cid = rec[3:0];
    cid_ok = {1'b0, cid} < 5'(tprd_pkg::MAX_CONTACTS);
    t = rec[4];
    px = {rec[19:16], rec[15:8]};
    py = {in_byte, rec[23:20]};
    verdict = tprd_pkg::VD_PASS;
    if (disc) verdict = tprd_pkg::VD_CONSUMED;
    else if (is_audio) verdict = tprd_pkg::VD_CONSUMED;
    else if (mt_en) begin
      case (rid)
        tprd_pkg::ID_KEYBOARD: verdict = tprd_pkg::VD_KEYBOARD;
        tprd_pkg::ID_DOUBLE:   verdict = tprd_pkg::VD_CONSUMED;
        tprd_pkg::ID_TOUCH:    verdict = size_bad ? tprd_pkg::VD_SIZE_ERR
                                                  : tprd_pkg::VD_CONSUMED;
        default:               verdict = tprd_pkg::VD_PASS;
      endcase
    end
    chg = held ^ nbtn;
    rd_addr = scan[3:0];
    out_free = !res_valid || m_tready;
    res_load = 1'b0;
    res_next = '0;
    mem_we = 1'b0;
    case (state)
      S_BYTE: if (out_free && rec_end) begin
        res_load = 1'b1;
        res_next.event_kind = tprd_pkg::EV_CONTACT;
        res_next.track_id = cid;
        res_next.touch_active = t;
        res_next.pos_x = px;
        res_next.pos_y = py;
        res_next.last = !at_end;
        mem_we = cid_ok;
      end
      S_FRAME: if (out_free) begin
        res_load = 1'b1;
        res_next.event_kind = tprd_pkg::EV_FRAME;
        res_next.any_touch = any_t;
      end
      S_BTN: if (out_free && btn != 2'd3 && chg[btn]) begin
        res_load = 1'b1;
        res_next.event_kind = tprd_pkg::EV_BUTTON;
        res_next.button_id = btn;
        res_next.button_pressed = nbtn[btn];
      end
      S_DONE: if (out_free) begin
        res_load = 1'b1;
        res_next.event_kind = tprd_pkg::EV_DONE;
        res_next.verdict = verdict;
        res_next.audio_update = is_audio && !disc;
        res_next.audio_inserted = is_audio && !disc && aud_nz;
        res_next.last = 1'b1;
      end
      S_DISC: if (out_free && scan[4] && disc_sent) begin
        res_load = 1'b1;
        res_next.event_kind = tprd_pkg::EV_FRAME;
      end
      S_DREAD: if (out_free) begin
        res_load = 1'b1;
        res_next.event_kind = tprd_pkg::EV_CONTACT;
        res_next.track_id = scan[3:0];
        res_next.pos_x = rd_data[11:0];
        res_next.pos_y = rd_data[23:12];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; audio_en <= 1'b0; mt_en <= 1'b0; active <= '0;
      held <= '0; nbtn <= '0; bidx <= '0; rid <= '0; rec <= '0; any_t <= 1'b0;
      size_bad <= 1'b0; aud_nz <= 1'b0; res_valid <= 1'b0; btn <= '0;
      scan <= '0; disc_sent <= 1'b0; res <= '0; disc <= 1'b0;
    end else begin
      res_valid <= res_load || (res_valid && !m_tready);
      if (res_load) res <= res_next;
      if (cfg_we) begin
        if (cfg_addr == tprd_pkg::REG_AUDIO) audio_en <= cfg_wdata;
        else mt_en <= cfg_wdata;
      end
      case (state)
        S_IDLE: if (s_tvalid) begin
          in_byte <= s_tdata[7:0];
          in_size <= s_tdata[15:8];
          disc <= s_tuser;
          if (s_tuser) begin
            scan <= '0; disc_sent <= 1'b0; state <= S_DISC;
          end else begin
            if (bidx == 8'd0) begin
              rid <= s_tdata[7:0];
              size_bad <= (s_tdata[15:8] < 8'd2) || (s_tdata[9:8] != 2'd2);
              aud_nz <= 1'b0; nbtn <= '0; any_t <= 1'b0; rec <= '0;
            end else if (bidx == 8'd1) begin
              aud_nz <= s_tdata[7:0] != 8'd0;
              nbtn <= s_tdata[3:1];
            end
            state <= S_BYTE;
          end
        end
        S_BYTE: if (out_free) begin
          if (rec_end) begin
            if (cid_ok) active[cid] <= t;
            if (t) any_t <= 1'b1;
          end else if (touch_ok && bidx >= 8'd2) begin
            case (bidx[1:0])
              2'd2: rec[7:0] <= in_byte;
              2'd3: rec[15:8] <= in_byte;
              default: rec[23:16] <= in_byte;
            endcase
          end
          if (!at_end) begin
            bidx <= bidx + 8'd1; state <= S_IDLE;
          end else begin
            btn <= '0;
            state <= (touch_ok && bidx >= 8'd5) ? S_FRAME
                   : (touch_ok ? S_BTN : S_DONE);
          end
        end
        S_FRAME: if (out_free) state <= S_BTN;
        S_BTN: if (out_free) begin
          if (btn == 2'd3) begin
            held <= nbtn; state <= S_DONE;
          end else begin
            btn <= btn + 2'd1;
          end
        end
        S_DONE: if (out_free) begin
          bidx <= '0; rid <= '0; rec <= '0; any_t <= 1'b0; size_bad <= 1'b0;
          aud_nz <= 1'b0; nbtn <= '0;
          state <= S_IDLE;
        end
        S_DISC: begin
          if (scan[4]) begin
            if (out_free) begin
              if (disc_sent) begin
                disc_sent <= 1'b0;
              end else begin
                nbtn <= '0; btn <= '0; state <= S_BTN;
              end
            end
          end else if (active[scan[3:0]]) begin
            state <= S_DREAD;
          end else scan <= scan + 5'd1;
        end
        S_DREAD: if (out_free) begin
          disc_sent <= 1'b1;
          active[scan[3:0]] <= 1'b0;
          scan <= scan + 5'd1; state <= S_DISC;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ src/tprd_checker.sv @@
// Port checker for touchpad_report_decoder, bound to the top level.
// Depends on tprd_pkg and the ports.
module tprd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic        m_tlast
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output item changed under stall");
  a_last_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] == tprd_pkg::EV_DONE |-> m_tlast)
    else $error("report done without last");
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("valid after reset");
  a_fill: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[39] == 1'b0)
    else $error("fill bits set");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while busy");
endmodule

bind touchpad_report_decoder tprd_checker u_tprd_checker (.*);
